// ===== rtl/assert_macros.svh =====
// assertion macros used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, pre, post, msg)
`endif
`endif

// ===== rtl/jtcf_pkg.sv =====
// shared constants, types and helpers of the trailing comma filter
package jtcf_pkg;

    localparam int WS_DEPTH_DEF = 32;

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // source of the next result byte
    typedef enum logic [1:0] {
        SEL_COMMA,
        SEL_SPACE,
        SEL_BYTE
    } emit_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      fetch;
        logic      emit;
        emit_sel_t sel;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic plan_comma;
        logic plan_buf;
        logic plan_byte;
        logic buf_more;
        logic byte_pend;
        logic out_free;
    } ctrl_status_t;

    function automatic logic is_space(input logic [7:0] b);
        return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
    endfunction

endpackage

// ===== rtl/json_trailing_comma_filter.sv =====
// top level: drops a comma before ']' or '}' outside strings, one item at a time
// order per item: load in S_IDLE, then S_COMMA, S_FETCH and S_SPACE per held space, S_BYTE
// each result is registered by an emit, which waits while the output register is not free
// an item with no result leaves the controller in S_IDLE; each held space costs a memory read and a send
// reset: synchronous active low aresetn clears string, escape, comma and count state
// the whitespace memory needs no clearing pass; its entries are written before read
module json_trailing_comma_filter import jtcf_pkg::*; #(
    parameter int WS_DEPTH = WS_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_text_end
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    jtcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    jtcf_datapath #(
        .WS_DEPTH (WS_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_in_byte    (s_in_byte),
        .s_final_byte (s_final_byte),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_text_end   (m_text_end),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== rtl/jtcf_datapath.sv =====
// datapath: string tracking, whitespace buffer memory and output register
`include "assert_macros.svh"
module jtcf_datapath import jtcf_pkg::*; #(
    parameter int WS_DEPTH = WS_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [7:0]   s_in_byte,
    input  logic         s_final_byte,
    input  logic         m_ready,
    output logic         m_valid,
    output logic [7:0]   m_out_byte,
    output logic         m_run_last,
    output logic         m_text_end,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status
);

    localparam int CW = $clog2(WS_DEPTH + 1);
    localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

    logic          in_string_reg, in_string_next;
    logic          escape_reg, escape_next;
    logic          comma_held_reg, comma_held_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    byte_reg;
    logic          fin_reg;
    logic          emit_byte_reg;
    logic [CW-1:0] flush_len_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          m_valid_reg;
    logic [7:0]    m_out_byte_reg;
    logic          m_run_last_reg;
    logic          m_text_end_reg;
    logic [7:0]    mem [WS_DEPTH];

    logic          p_comma;
    logic          p_byte;
    logic [CW-1:0] p_len;
    logic          store;
    logic          plain;
    logic          sp;
    logic          full;
    logic          drop;
    logic          emit_last;

    // plan for the item at the input: what to emit and the next state
    always_comb begin
        sp              = is_space(s_in_byte);
        full            = (count_reg == CW'(WS_DEPTH));
        drop            = (s_in_byte == CH_RBRACK) || (s_in_byte == CH_RBRACE);
        p_comma         = 1'b0;
        p_byte          = 1'b0;
        p_len           = '0;
        store           = 1'b0;
        plain           = 1'b0;
        in_string_next  = in_string_reg;
        escape_next     = escape_reg;
        comma_held_next = comma_held_reg;
        count_next      = count_reg;
        if (comma_held_reg) begin
            if (sp && !full) begin
                store      = 1'b1;
                count_next = count_reg + 1'b1;
                if (s_final_byte) begin
                    p_comma = 1'b1;
                    p_len   = count_reg + 1'b1;
                end
            end else if (sp) begin
                // whitespace overflow: keep the comma, flush, pass the byte
                p_comma         = 1'b1;
                p_len           = count_reg;
                p_byte          = 1'b1;
                comma_held_next = 1'b0;
                count_next      = '0;
            end else begin
                p_comma         = !drop;
                p_len           = count_reg;
                comma_held_next = 1'b0;
                count_next      = '0;
                plain           = 1'b1;
            end
        end else begin
            plain = 1'b1;
        end
        if (plain) begin
            if (in_string_reg) begin
                p_byte = 1'b1;
                if (escape_reg) begin
                    escape_next = 1'b0;
                end else if (s_in_byte == CH_BSLASH) begin
                    escape_next = 1'b1;
                end else if (s_in_byte == CH_QUOTE) begin
                    in_string_next = 1'b0;
                end
            end else if (s_in_byte == CH_QUOTE) begin
                in_string_next = 1'b1;
                p_byte         = 1'b1;
            end else if (s_in_byte == CH_COMMA) begin
                if (s_final_byte) begin
                    p_byte = 1'b1;
                end else begin
                    comma_held_next = 1'b1;
                    count_next      = '0;
                end
            end else begin
                p_byte = 1'b1;
            end
        end
        // end of text clears all tracking
        if (s_final_byte) begin
            in_string_next  = 1'b0;
            escape_next     = 1'b0;
            comma_held_next = 1'b0;
            count_next      = '0;
        end
    end

    // status toward the controller
    always_comb begin
        status.plan_comma = p_comma;
        status.plan_buf   = (p_len != '0);
        status.plan_byte  = p_byte;
        status.buf_more   = (rd_idx_reg != flush_len_reg);
        status.byte_pend  = emit_byte_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

    // last result of the item for the selected source
    always_comb begin
        case (cmd.sel)
            SEL_COMMA: emit_last = (flush_len_reg == '0) && !emit_byte_reg;
            SEL_SPACE: emit_last = (rd_idx_reg == flush_len_reg) && !emit_byte_reg;
            SEL_BYTE:  emit_last = 1'b1;
            default:   emit_last = 1'b1;
        endcase
    end

    // whitespace buffer memory
    always_ff @(posedge aclk) begin
        if (cmd.load && store) begin
            mem[count_reg[AW-1:0]] <= s_in_byte;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // tracking state, item latch and read index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_string_reg  <= 1'b0;
            escape_reg     <= 1'b0;
            comma_held_reg <= 1'b0;
            count_reg      <= '0;
            emit_byte_reg  <= 1'b0;
            flush_len_reg  <= '0;
            rd_idx_reg     <= '0;
        end else if (cmd.load) begin
            in_string_reg  <= in_string_next;
            escape_reg     <= escape_next;
            comma_held_reg <= comma_held_next;
            count_reg      <= count_next;
            emit_byte_reg  <= p_byte;
            flush_len_reg  <= p_len;
            rd_idx_reg     <= '0;
        end else if (cmd.fetch) begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_in_byte;
            fin_reg  <= s_final_byte;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            case (cmd.sel)
                SEL_COMMA: m_out_byte_reg <= CH_COMMA;
                SEL_SPACE: m_out_byte_reg <= rd_data_reg;
                default:   m_out_byte_reg <= byte_reg;
            endcase
            m_run_last_reg <= emit_last;
            m_text_end_reg <= emit_last && fin_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_run_last = m_run_last_reg;
    assign m_text_end = m_text_end_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(WS_DEPTH), "space count beyond depth")
    `ASSERT_IMPLY(a_held_outside, comma_held_reg, !in_string_reg, "comma held inside string")
    `ASSERT_IMPLY(a_count_held, count_reg != '0, comma_held_reg, "spaces held without comma")
    `ASSERT_IMPLY(a_fetch_range, cmd.fetch, rd_idx_reg != flush_len_reg, "fetch past flush")
    `ASSERT_IMPLY(a_emit_room, cmd.emit, !m_valid_reg || m_ready, "output overwritten")

endmodule

// ===== rtl/jtcf_ctrl.sv =====
// controller: sequences comma, buffered whitespace and byte per item
module jtcf_ctrl import jtcf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMA,
        S_FETCH,
        S_SPACE,
        S_BYTE
    } state_t;

    state_t state_reg, state_next;

    // commands and next state
    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.fetch  = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_BYTE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.plan_comma) begin
                        state_next = S_COMMA;
                    end else if (status.plan_buf) begin
                        state_next = S_FETCH;
                    end else if (status.plan_byte) begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_COMMA: begin
                cmd.sel = SEL_COMMA;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.buf_more) begin
                        state_next = S_FETCH;
                    end else if (status.byte_pend) begin
                        state_next = S_BYTE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_SPACE;
            end
            S_SPACE: begin
                cmd.sel = SEL_SPACE;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.buf_more) begin
                        state_next = S_FETCH;
                    end else if (status.byte_pend) begin
                        state_next = S_BYTE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BYTE: begin
                cmd.sel = SEL_BYTE;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
